@@ rtl/rz_serial_frame_decoder_crc16_defines.svh @@
// Assertion macros for the RZ serial frame decoder.
// Used by the top level; relies on clk and arst_n being in scope.
`ifndef RZ_SERIAL_FRAME_DECODER_CRC16_DEFINES_SVH
`define RZ_SERIAL_FRAME_DECODER_CRC16_DEFINES_SVH

// Property must hold on every clock edge outside reset.
`define RZSFD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define RZSFD_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

@@ rtl/rzsfd_pkg.sv @@
// Shared types, constants and the byte-wide CRC-16 function
// for the RZ serial frame decoder. No dependencies.
package rzsfd_pkg;

	localparam int COUNT_WIDTH = 10;
	localparam int SPB_W       = 10;
	localparam int TOL_W       = 7;
	localparam int THR_W       = 10;
	localparam int CFG_DATA_W  = 10;
	localparam int CFG_IDX_W   = 2;
	localparam int FRAME_BITS  = 11;
	localparam int BIT_POS_W   = 4;
	localparam int CRC_W       = 16;
	localparam int FRAME_CNT_W = 16;

	localparam logic [CRC_W-1:0]       CRC_POLY      = 16'h8005;
	localparam logic [7:0]             SILENCE_LEVEL = 8'h80;
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX       = '1;

	localparam logic [SPB_W-1:0] SPB_RESET = 10'd441;
	localparam logic [TOL_W-1:0] TOL_RESET = 7'd3;
	localparam logic [THR_W-1:0] THR_RESET = 10'd147;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SAMPLES_PER_BIT = 2'd0,
		REG_NOISE_TOLERANCE = 2'd1,
		REG_MARK_THRESHOLD  = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [SPB_W-1:0] spb;
		logic [TOL_W-1:0] tol;
		logic [THR_W-1:0] thr;
	} cfg_t;

	typedef struct packed {
		logic [7:0]             data_byte;
		logic                   frame_ok;
		logic                   start_error;
		logic                   stop1_error;
		logic                   stop2_error;
		logic                   silence_violation;
		logic [CRC_W-1:0]       crc_value;
		logic                   crc_zero;
		logic [FRAME_CNT_W-1:0] frame_index;
	} res_t;

	// CRC-16, MSB first, one byte unrolled over eight shift steps
	function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc,
		input logic [7:0] data);
		logic [CRC_W-1:0] c;
		c = crc ^ {data, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[CRC_W-1]) begin
				c = (c << 1) ^ CRC_POLY;
			end else begin
				c = c << 1;
			end
		end
		return c;
	endfunction

endpackage

@@ rtl/rzsfd_cfg.sv @@
// Configuration register file for the RZ serial frame decoder.
// Depends on rzsfd_pkg.
module rzsfd_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [rzsfd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rzsfd_pkg::CFG_DATA_W-1:0]    cfg_data,
	output rzsfd_pkg::cfg_t                     cfg
);

	logic [rzsfd_pkg::SPB_W-1:0] spb_q;
	logic [rzsfd_pkg::TOL_W-1:0] tol_q;
	logic [rzsfd_pkg::THR_W-1:0] thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spb_q <= rzsfd_pkg::SPB_RESET;
			tol_q <= rzsfd_pkg::TOL_RESET;
			thr_q <= rzsfd_pkg::THR_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rzsfd_pkg::REG_SAMPLES_PER_BIT: begin
					spb_q <= cfg_data[rzsfd_pkg::SPB_W-1:0];
				end
				rzsfd_pkg::REG_NOISE_TOLERANCE: begin
					tol_q <= cfg_data[rzsfd_pkg::TOL_W-1:0];
				end
				rzsfd_pkg::REG_MARK_THRESHOLD: begin
					thr_q <= cfg_data[rzsfd_pkg::THR_W-1:0];
				end
				default: begin
					// unmapped index: write dropped
				end
			endcase
		end
	end

	assign cfg.spb = spb_q;
	assign cfg.tol = tol_q;
	assign cfg.thr = thr_q;

endmodule

@@ rtl/rzsfd_core.sv @@
// Per-sample decode: mark detect, bit timing, frame assembly and CRC update.
// Depends on rzsfd_pkg.
module rzsfd_core (
	input  logic             clk,
	input  logic             arst_n,
	input  rzsfd_pkg::cfg_t  cfg,
	input  logic             step,
	input  logic [7:0]       sample,
	output logic             frame_done,
	output rzsfd_pkg::res_t  res
);

	logic [rzsfd_pkg::SPB_W-1:0]       sample_pos_q;
	logic [rzsfd_pkg::BIT_POS_W-1:0]   bit_pos_q;
	logic [rzsfd_pkg::COUNT_WIDTH-1:0] mark_cnt_q;
	logic [rzsfd_pkg::FRAME_BITS-1:0]  frame_bits_q;
	logic                              viol_q;
	logic [rzsfd_pkg::CRC_W-1:0]       crc_q;
	logic [rzsfd_pkg::FRAME_CNT_W-1:0] frame_cnt_q;

	logic [8:0]                        lo_lim, hi_lim;
	logic                              is_mark, first_half, cnt_inc, bit_end, bit_val;
	logic [rzsfd_pkg::SPB_W-1:0]       half;
	logic [rzsfd_pkg::SPB_W:0]         pos_inc;
	logic [rzsfd_pkg::COUNT_WIDTH-1:0] cnt_nxt;
	logic                              viol_nxt;
	logic [rzsfd_pkg::FRAME_BITS-1:0]  bits_nxt;
	logic                              start_err, stop1_err, stop2_err, ok;
	logic [7:0]                        byte_val;
	logic [rzsfd_pkg::CRC_W-1:0]       crc_nxt;

	always_comb begin
		lo_lim     = 9'(rzsfd_pkg::SILENCE_LEVEL) - 9'(cfg.tol);
		hi_lim     = 9'(rzsfd_pkg::SILENCE_LEVEL) + 9'(cfg.tol);
		is_mark    = (9'(sample) < lo_lim) || (9'(sample) > hi_lim);
		half       = cfg.spb >> 1;
		first_half = sample_pos_q < half;
		cnt_inc    = is_mark && first_half && (mark_cnt_q != rzsfd_pkg::CNT_MAX);
		cnt_nxt    = mark_cnt_q + rzsfd_pkg::COUNT_WIDTH'(cnt_inc);
		viol_nxt   = viol_q | (is_mark && !first_half);
		// bit ends once position + 1 reaches or passes the period
		pos_inc    = {1'b0, sample_pos_q} + (rzsfd_pkg::SPB_W + 1)'(1);
		bit_end    = pos_inc >= {1'b0, cfg.spb};
		bit_val    = 17'(cnt_nxt) > 17'(cfg.thr);
		bits_nxt   = frame_bits_q
			| (rzsfd_pkg::FRAME_BITS'(bit_val) << bit_pos_q);
		frame_done = bit_end
			&& (bit_pos_q == rzsfd_pkg::BIT_POS_W'(rzsfd_pkg::FRAME_BITS - 1));
		start_err  = !bits_nxt[0];
		stop1_err  = bits_nxt[9];
		stop2_err  = bits_nxt[10];
		ok         = !(start_err || stop1_err || stop2_err);
		byte_val   = bits_nxt[8:1];
		crc_nxt    = ok ? rzsfd_pkg::crc16_byte(crc_q, byte_val) : crc_q;
	end

	always_comb begin
		res.data_byte         = byte_val;
		res.frame_ok          = ok;
		res.start_error       = start_err;
		res.stop1_error       = stop1_err;
		res.stop2_error       = stop2_err;
		res.silence_violation = viol_nxt;
		res.crc_value         = crc_nxt;
		res.crc_zero          = (crc_nxt == '0);
		res.frame_index       = frame_cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_pos_q <= '0;
			bit_pos_q    <= '0;
			mark_cnt_q   <= '0;
			frame_bits_q <= '0;
			viol_q       <= 1'b0;
			crc_q        <= '0;
			frame_cnt_q  <= '0;
		end else if (step) begin
			if (!bit_end) begin
				sample_pos_q <= pos_inc[rzsfd_pkg::SPB_W-1:0];
				mark_cnt_q   <= cnt_nxt;
				viol_q       <= viol_nxt;
			end else begin
				sample_pos_q <= '0;
				mark_cnt_q   <= '0;
				if (frame_done) begin
					bit_pos_q    <= '0;
					frame_bits_q <= '0;
					viol_q       <= 1'b0;
					crc_q        <= crc_nxt;
					frame_cnt_q  <= frame_cnt_q + 1'b1;
				end else begin
					bit_pos_q    <= bit_pos_q + 1'b1;
					frame_bits_q <= bits_nxt;
					viol_q       <= viol_nxt;
				end
			end
		end
	end

endmodule

@@ rtl/rz_serial_frame_decoder_crc16.sv @@
// RZ serial frame decoder with running CRC-16, top level; uses rzsfd_cfg and rzsfd_core.
// A frame's last sample is registered in stage 1, its result in the output register.
// Throughput: one sample per cycle; input stalls only when a frame-ending sample
// meets a result still held in the output register while out_ready is low.
// Reset: arst_n asynchronous, active low; clears all state but sample_s1 and res_q;
// config back to 441 / 3 / 147.
`include "rz_serial_frame_decoder_crc16_defines.svh"

module rz_serial_frame_decoder_crc16 (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write port
	input  logic                               cfg_we,
	input  logic [rzsfd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rzsfd_pkg::CFG_DATA_W-1:0]   cfg_data,
	// sample channel
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [7:0]                         sample,
	// frame result channel
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [7:0]                         data_byte,
	output logic                               frame_ok,
	output logic                               start_error,
	output logic                               stop1_error,
	output logic                               stop2_error,
	output logic                               silence_violation,
	output logic [rzsfd_pkg::CRC_W-1:0]        crc_value,
	output logic                               crc_zero,
	output logic [rzsfd_pkg::FRAME_CNT_W-1:0]  frame_index
);

	rzsfd_pkg::cfg_t cfg;
	rzsfd_pkg::res_t core_res;
	rzsfd_pkg::res_t res_q;

	// Stage 1: registered sample
	logic       valid_s1;
	logic [7:0] sample_s1;

	logic out_valid_q;
	logic frame_done;
	logic advance;     // s1 sample is consumed by the core this cycle
	logic res_load;    // core result goes into the output register
	logic in_xfer;

	rzsfd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	rzsfd_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.step       (advance),
		.sample     (sample_s1),
		.frame_done (frame_done),
		.res        (core_res)
	);

	// The s1 sample only has to wait when it closes a frame and the output
	// register is full and not draining. Other samples keep flowing even
	// while a result sits unclaimed.
	assign advance  = valid_s1
		&& !(frame_done && out_valid_q && !out_ready);
	assign res_load = advance && frame_done;
	assign in_ready = !valid_s1 || advance;
	assign in_xfer  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			sample_s1 <= sample;
		end
	end

	// Output register: one frame result, held until transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= core_res;
		end
	end

	assign out_valid         = out_valid_q;
	assign data_byte         = res_q.data_byte;
	assign frame_ok          = res_q.frame_ok;
	assign start_error       = res_q.start_error;
	assign stop1_error       = res_q.stop1_error;
	assign stop2_error       = res_q.stop2_error;
	assign silence_violation = res_q.silence_violation;
	assign crc_value         = res_q.crc_value;
	assign crc_zero          = res_q.crc_zero;
	assign frame_index       = res_q.frame_index;

	// A held result is never overwritten.
	`RZSFD_NEVER(a_no_overwrite, res_load && out_valid_q && !out_ready, "result overwritten")
	// Input stalls only on a frame-ending sample.
	`RZSFD_ASSERT(a_stall_cause, !in_ready |-> (valid_s1 && frame_done), "spurious input stall")
	// Framing flags agree with frame_ok.
	`RZSFD_ASSERT(a_ok_flags, out_valid |-> (frame_ok == !(start_error || stop1_error || stop2_error)), "frame_ok mismatch")

endmodule

@@ dv/rz_serial_frame_decoder_crc16_test.sv @@
// Self-checking testbench for the RZ serial frame decoder with running CRC-16.
// Drives audio samples and register writes, decodes frames in a local model and
// checks every frame result. Depends on rzsfd_pkg and rz_serial_frame_decoder_crc16.
`timescale 1ns / 1ps

module rz_serial_frame_decoder_crc16_test;

	// cycles without any transfer before the run is declared hung
	localparam int STALL_LIMIT = 5000;
	// samples sent by the random stream
	localparam int RANDOM_ITEMS = 500;
	// register index that maps to nothing; writes to it must be ignored
	localparam logic [rzsfd_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	logic                              clk;
	logic                              arst_n;
	logic                              cfg_we;
	logic [rzsfd_pkg::CFG_IDX_W-1:0]   cfg_index;
	logic [rzsfd_pkg::CFG_DATA_W-1:0]  cfg_data;
	logic                              in_valid;
	logic                              in_ready;
	logic [7:0]                        sample;
	logic                              out_valid;
	logic                              out_ready;
	logic [7:0]                        data_byte;
	logic                              frame_ok;
	logic                              start_error;
	logic                              stop1_error;
	logic                              stop2_error;
	logic                              silence_violation;
	logic [rzsfd_pkg::CRC_W-1:0]       crc_value;
	logic                              crc_zero;
	logic [rzsfd_pkg::FRAME_CNT_W-1:0] frame_index;

	rz_serial_frame_decoder_crc16 i_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.sample            (sample),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.data_byte         (data_byte),
		.frame_ok          (frame_ok),
		.start_error       (start_error),
		.stop1_error       (stop1_error),
		.stop2_error       (stop2_error),
		.silence_violation (silence_violation),
		.crc_value         (crc_value),
		.crc_zero          (crc_zero),
		.frame_index       (frame_index)
	);

	// 4 ns period
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// ------------------------------------------------------------------
	// Local decoder model: register copies and frame state.
	// Updated on every sample transfer; each completed frame is queued.
	// ------------------------------------------------------------------
	logic [rzsfd_pkg::SPB_W-1:0]       spb_reg     = rzsfd_pkg::SPB_RESET;
	logic [rzsfd_pkg::TOL_W-1:0]       tol_reg     = rzsfd_pkg::TOL_RESET;
	logic [rzsfd_pkg::THR_W-1:0]       thr_reg     = rzsfd_pkg::THR_RESET;
	logic [rzsfd_pkg::SPB_W-1:0]       pos_q       = '0;
	logic [rzsfd_pkg::BIT_POS_W-1:0]   bitpos_q    = '0;
	logic [rzsfd_pkg::COUNT_WIDTH-1:0] marks_q     = '0;
	logic [rzsfd_pkg::FRAME_BITS-1:0]  bits_q      = '0;
	logic                              viol_q      = 1'b0;
	logic [rzsfd_pkg::CRC_W-1:0]       crc_q       = '0;
	logic [rzsfd_pkg::FRAME_CNT_W-1:0] frame_cnt_q = '0;

	rzsfd_pkg::res_t frames_due[$];     // decoded frames not yet seen on the output
	rzsfd_pkg::res_t want, got;

	int gap_max        = 4;  // per-transfer idle draw, both sides
	int stall_left     = 0;  // receiver stall for the next result
	int hold_left      = 0;  // long receiver hold-off, counted down per cycle
	int samples_sent   = 0;
	int frames_seen    = 0;
	int mismatch_count = 0;
	int quiet_cycles   = 0;

	// CRC-16 (0x8005), fed one data bit at a time, MSB first
	function automatic logic [rzsfd_pkg::CRC_W-1:0] crc16_shift_in(
		input logic [rzsfd_pkg::CRC_W-1:0] crc, input logic [7:0] d);
		logic [rzsfd_pkg::CRC_W-1:0] c;
		logic                        fb;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = c[rzsfd_pkg::CRC_W-1] ^ d[i];
			c  = {c[rzsfd_pkg::CRC_W-2:0], 1'b0};
			if (fb) begin
				c = c ^ rzsfd_pkg::CRC_POLY;
			end
		end
		return c;
	endfunction

	// Advance the model by one sample; queue a frame when bit 10 closes.
	function automatic void decode_sample(input logic [7:0] s);
		logic                        is_mark;
		logic [rzsfd_pkg::SPB_W-1:0] half;
		rzsfd_pkg::res_t             r;
		is_mark = (int'(s) < int'(rzsfd_pkg::SILENCE_LEVEL) - int'(tol_reg)) ||
			(int'(s) > int'(rzsfd_pkg::SILENCE_LEVEL) + int'(tol_reg));
		half = spb_reg >> 1;
		if (is_mark) begin
			if (pos_q < half) begin
				if (marks_q != rzsfd_pkg::CNT_MAX) begin
					marks_q++;
				end
			end else begin
				viol_q = 1'b1;
			end
		end
		// bit period ends once position + 1 reaches the period, even after a cut
		if (int'(pos_q) + 1 < int'(spb_reg)) begin
			pos_q++;
			return;
		end
		if (marks_q > thr_reg) begin
			bits_q[bitpos_q] = 1'b1;
		end
		pos_q   = '0;
		marks_q = '0;
		bitpos_q++;
		if (bitpos_q < rzsfd_pkg::FRAME_BITS) begin
			return;
		end
		r.start_error = ~bits_q[0];
		r.stop1_error = bits_q[9];
		r.stop2_error = bits_q[10];
		r.frame_ok    = ~(r.start_error | r.stop1_error | r.stop2_error);
		r.data_byte   = bits_q[8:1];
		// framing errors leave the CRC alone; violations do not matter here
		if (r.frame_ok) begin
			crc_q = crc16_shift_in(crc_q, r.data_byte);
		end
		r.silence_violation = viol_q;
		r.crc_value         = crc_q;
		r.crc_zero          = (crc_q == '0);
		r.frame_index       = frame_cnt_q;
		frames_due.push_back(r);
		frame_cnt_q++;
		bitpos_q = '0;
		bits_q   = '0;
		viol_q   = 1'b0;
	endfunction

	function automatic void flag_error(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("[%0t] %s", $time, msg);
		end
	endfunction

	// ------------------------------------------------------------------
	// Result side: check each transfer against the oldest decoded frame.
	// Sampled at the rising edge, so values are the pre-edge ones.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			frames_seen++;
			stall_left = $urandom_range(0, gap_max);
			got = {data_byte, frame_ok, start_error, stop1_error, stop2_error,
				silence_violation, crc_value, crc_zero, frame_index};
			if (frames_due.size() == 0) begin
				flag_error($sformatf("unexpected frame: byte %02h crc %04h index %0d",
					got.data_byte, got.crc_value, got.frame_index));
			end else begin
				want = frames_due.pop_front();
				if (got.data_byte !== want.data_byte || got.frame_ok !== want.frame_ok ||
					got.start_error !== want.start_error ||
					got.stop1_error !== want.stop1_error ||
					got.stop2_error !== want.stop2_error ||
					got.silence_violation !== want.silence_violation ||
					got.crc_value !== want.crc_value || got.crc_zero !== want.crc_zero ||
					got.frame_index !== want.frame_index) begin
					flag_error($sformatf({"frame %0d: expected byte %02h ok %b err %b%b%b ",
						"viol %b crc %04h zero %b idx %0d, got byte %02h ok %b err %b%b%b ",
						"viol %b crc %04h zero %b idx %0d"}, frames_seen - 1,
						want.data_byte, want.frame_ok, want.start_error, want.stop1_error,
						want.stop2_error, want.silence_violation, want.crc_value,
						want.crc_zero, want.frame_index, got.data_byte, got.frame_ok,
						got.start_error, got.stop1_error, got.stop2_error,
						got.silence_violation, got.crc_value, got.crc_zero,
						got.frame_index));
				end
			end
		end
	end

	// Receiver: random per-result stall, plus an optional long hold-off
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog: any transfer or register write counts as progress
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles + 1 >= STALL_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// One sample transfer. Valid stays up after the transfer; the next call
	// (or settle) drops it at the following falling edge, unless that call draws no gap.
	task automatic send_sample(input logic [7:0] s);
		int gap;
		gap = $urandom_range(0, gap_max);
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		sample   <= s;
		do @(posedge clk); while (!in_ready);
		decode_sample(s);
		samples_sent++;
	endtask

	// Drop valid and wait until every decoded frame has come out, plus slack
	// for a sample still in the pipe.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (frames_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [rzsfd_pkg::CFG_IDX_W-1:0] idx,
		input logic [rzsfd_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			rzsfd_pkg::REG_SAMPLES_PER_BIT: spb_reg = val;
			rzsfd_pkg::REG_NOISE_TOLERANCE: tol_reg = val[rzsfd_pkg::TOL_W-1:0];
			rzsfd_pkg::REG_MARK_THRESHOLD:  thr_reg = val;
			default: ;
		endcase
	endtask

	task automatic configure(input logic [rzsfd_pkg::CFG_DATA_W-1:0] spb,
		input logic [rzsfd_pkg::CFG_DATA_W-1:0] tol,
		input logic [rzsfd_pkg::CFG_DATA_W-1:0] thr);
		settle();
		write_reg(rzsfd_pkg::REG_SAMPLES_PER_BIT, spb);
		write_reg(rzsfd_pkg::REG_NOISE_TOLERANCE, tol);
		write_reg(rzsfd_pkg::REG_MARK_THRESHOLD, thr);
	endtask

	// random level outside the silence band (only below it when tol is 127)
	function automatic logic [7:0] mark_level();
		int lo_top, hi_bot;
		lo_top = 127 - int'(tol_reg);
		hi_bot = 129 + int'(tol_reg);
		if (hi_bot > 255 || $urandom_range(0, 1) == 0) begin
			return 8'($urandom_range(0, lo_top));
		end
		return 8'($urandom_range(hi_bot, 255));
	endfunction

	function automatic logic [7:0] quiet_level();
		return 8'($urandom_range(128 - int'(tol_reg), 128 + int'(tol_reg)));
	endfunction

	// One bit period: marks in the first half for a one (some dropped),
	// silence otherwise, stray marks in the second half.
	task automatic send_bit(input logic b, input int stray_pct, input int drop_pct);
		int n, half;
		n    = (spb_reg == '0) ? 1 : int'(spb_reg);
		half = int'(spb_reg) / 2;
		for (int p = 0; p < n; p++) begin
			if (p < half) begin
				if (b && int'($urandom_range(1, 100)) > drop_pct) begin
					send_sample(mark_level());
				end else begin
					send_sample(quiet_level());
				end
			end else if (int'($urandom_range(1, 100)) <= stray_pct) begin
				send_sample(mark_level());
			end else begin
				send_sample(quiet_level());
			end
		end
	endtask

	task automatic send_frame(input logic [rzsfd_pkg::FRAME_BITS-1:0] fb,
		input int stray_pct, input int drop_pct);
		for (int i = 0; i < rzsfd_pkg::FRAME_BITS; i++) begin
			send_bit(fb[i], stray_pct, drop_pct);
		end
	endtask

	// start bit 1, byte LSB first, two zero stop bits
	function automatic logic [rzsfd_pkg::FRAME_BITS-1:0] frame_of(input logic [7:0] b);
		return {2'b00, b, 1'b1};
	endfunction

	// pad with silence until the model sits on a frame boundary
	task automatic resync();
		while (pos_q != '0 || bitpos_q != '0) send_sample(quiet_level());
	endtask

	// append the current CRC, high byte first; the stream then checks to zero
	task automatic seal_crc();
		logic [rzsfd_pkg::CRC_W-1:0] c;
		resync();
		c = crc_q;
		send_frame(frame_of(c[15:8]), 0, 0);
		send_frame(frame_of(c[7:0]), 0, 0);
	endtask

	task automatic random_config();
		logic [rzsfd_pkg::CFG_DATA_W-1:0] spb, thr;
		int r;
		r = $urandom_range(1, 100);
		if (r <= 75) begin
			spb = 10'($urandom_range(2, 10));
		end else if (r <= 95) begin
			spb = 10'($urandom_range(11, 40));
		end else begin
			spb = 10'($urandom_range(0, 1));
		end
		// mostly a threshold that lets a clean one-bit decode
		if (spb >= 2 && $urandom_range(1, 100) <= 85) begin
			thr = 10'($urandom_range(0, int'(spb) / 2 - 1));
		end else begin
			thr = 10'($urandom_range(0, 1023));
		end
		configure(spb, 10'($urandom), thr);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// reset values 441 / 3 / 147, no writes yet: bit 0 runs past its half at
	// the default period, then the period is cut and the frame closes at the
	// default threshold
	task automatic test_reset_defaults();
		gap_max = 4;
		for (int p = 0; p < 230; p++) begin
			if ($urandom_range(1, 100) <= 80) begin
				send_sample(mark_level());
			end else begin
				send_sample(quiet_level());
			end
		end
		// silence band edges at tolerance 3
		send_sample(8'h7C);
		send_sample(8'h7D);
		send_sample(8'h83);
		send_sample(8'h84);
		settle();
		write_reg(rzsfd_pkg::REG_SAMPLES_PER_BIT, 10'd2);
		resync();
	endtask

	task automatic test_directed_frames();
		configure(4, 0, 1);
		send_frame(frame_of(8'h00), 0, 0);
		send_frame(frame_of(8'hFF), 0, 0);
		send_frame(frame_of(8'h01), 0, 0);
		send_frame(frame_of(8'h80), 0, 0);
		// framing errors: missing start, each stop bit, all at once
		send_frame({2'b00, 8'h6B, 1'b0}, 0, 0);
		send_frame({1'b0, 1'b1, 8'h6B, 1'b1}, 0, 0);
		send_frame({1'b1, 1'b0, 8'h6B, 1'b1}, 0, 0);
		send_frame({2'b11, 8'h3C, 1'b0}, 0, 0);
		// marks in every second half
		send_frame(frame_of(8'h5A), 100, 0);
		// sample extremes and the silence edges at zero tolerance
		send_sample(8'h00);
		send_sample(8'hFF);
		send_sample(8'h7F);
		send_sample(8'h80);
		send_sample(8'h81);
		resync();
		seal_crc();
		// widest tolerance: only 0x00 is a mark
		configure(4, 127, 1);
		send_frame(frame_of(8'hC3), 0, 0);
		repeat (3) send_sample(8'hFF);
		resync();
		// unmapped index is ignored; upper data bits of the tolerance are dropped
		settle();
		write_reg(REG_UNUSED, '1);
		write_reg(rzsfd_pkg::REG_NOISE_TOLERANCE, 10'h385);
		send_frame(frame_of(8'h2E), 20, 0);
	endtask

	// periods of 0 and 1: each sample closes a bit, every mark is a violation
	task automatic test_short_period();
		configure(0, 0, 0);
		repeat (11) send_sample(mark_level());
		repeat (11) send_sample(quiet_level());
		configure(1, 0, 0);
		repeat (11) send_sample(mark_level());
		repeat (11) send_sample(quiet_level());
	endtask

	// shrink the period below the current position in the middle of a bit
	task automatic test_period_cut();
		configure(8, 2, 2);
		resync();
		repeat (6) send_sample(mark_level());
		settle();
		write_reg(rzsfd_pkg::REG_SAMPLES_PER_BIT, 3);
		resync();
		send_frame(frame_of(8'h71), 0, 0);
	endtask

	task automatic test_register_extremes();
		// longest period: run bit 0 past its half, with a mark right at the
		// half boundary, then cut the period and close the frame
		gap_max = 0;
		configure(1023, 0, 0);
		resync();
		for (int p = 0; p < 520; p++) begin
			if (p % 7 == 0) begin
				send_sample(mark_level());
			end else begin
				send_sample(quiet_level());
			end
		end
		settle();
		write_reg(rzsfd_pkg::REG_SAMPLES_PER_BIT, 10'd6);
		resync();
		gap_max = 4;
		// threshold at its top: every bit reads zero
		configure(6, 3, 1023);
		send_frame(frame_of(8'hE7), 0, 0);
		configure(6, 3, 0);
		send_frame(frame_of(8'h18), 10, 10);
	endtask

	// receiver holds off long enough for the output register to back up
	// into the sample channel
	task automatic test_backpressure();
		configure(2, 0, 0);
		gap_max = 1;
		@(posedge clk);
		hold_left = 400;
		repeat (6) send_frame(frame_of(8'($urandom)), 0, 0);
		gap_max = 4;
	endtask

	task automatic test_random_stream();
		int start_items, kind;
		start_items = samples_sent;
		random_config();
		while (samples_sent - start_items < RANDOM_ITEMS) begin
			if ($urandom_range(0, 3) == 0) begin
				gap_max = ($urandom_range(0, 3) == 0) ? 0 : 4;
				random_config();
			end
			kind = $urandom_range(1, 100);
			if (kind <= 60) begin
				// well-formed frame, sometimes with stray or dropped marks
				resync();
				send_frame(frame_of(8'($urandom)),
					($urandom_range(0, 1) == 0) ? 0 : int'($urandom_range(0, 20)),
					($urandom_range(0, 1) == 0) ? 0 : int'($urandom_range(0, 30)));
			end else if (kind <= 70) begin
				seal_crc();
			end else if (kind <= 85) begin
				send_frame(11'($urandom), $urandom_range(0, 40), $urandom_range(0, 40));
			end else begin
				repeat ($urandom_range(1, 30)) send_sample(8'($urandom));
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		in_valid  = 1'b0;
		sample    = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_directed_frames();
		test_short_period();
		test_period_cut();
		test_register_extremes();
		test_backpressure();
		test_random_stream();

		settle();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && frames_due.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

@@ rz_serial_frame_decoder_crc16.f @@
+incdir+rtl
rtl/rzsfd_pkg.sv
rtl/rzsfd_cfg.sv
rtl/rzsfd_core.sv
rtl/rz_serial_frame_decoder_crc16.sv
dv/rz_serial_frame_decoder_crc16_test.sv
